/* hw/rtl/teab_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teab_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package teab_pkg;

	localparam int DEF_MAX_FACES   = 1024;
	localparam int DEF_VERTEX_BITS = 32;

	localparam int ACTION_W   = 2;
	localparam int VIN_W      = 32;
	localparam int SLOT_IN_W  = 12;
	localparam int STATUS_W   = 2;
	localparam int NB_OUT_W   = 10;
	localparam int FC_OUT_W   = 11;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_BUILD = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_BUILT = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic read_issue;
		logic read_finish;
		logic build_start;
		logic clr_write;
		logic p_latch;
		logic q_issue;
		logic q_step;
		logic pair_p;
		logic pair_q;
		logic p_step;
		logic build_done;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slots_zero;
		logic clr_last;
		logic p_paired;
		logic p_last;
		logic q_match;
		logic q_first;
	} stat_t;

endpackage

/* hw/rtl/teab_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teab_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module teab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/teab_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teab_ctrl
// Command sequencer: decodes items, drives the clear pass and steps the pairing scan.
// ----------------------------------------------------------------------------
module teab_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [teab_pkg::ACTION_W-1:0] action,
	input  teab_pkg::stat_t               st,
	output teab_pkg::cmd_t                cmd,
	output logic                          busy
);
	import teab_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_RD_WAIT = 9'b000000010,
		S_CLR     = 9'b000000100,
		S_P_RD    = 9'b000001000,
		S_P_CHK   = 9'b000010000,
		S_Q_RD    = 9'b000100000,
		S_Q_CHK   = 9'b001000000,
		S_PAIR_P  = 9'b010000000,
		S_PAIR_Q  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	action_t act;

	assign act  = action_t'(action);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (act)
						ACT_LOAD:  cmd.load = 1'b1;
						ACT_CLEAR: cmd.clear = 1'b1;
						ACT_READ: begin
							cmd.read_issue = 1'b1;
							state_d = S_RD_WAIT;
						end
						ACT_BUILD: begin
							cmd.build_start = 1'b1;
							if (st.slots_zero) begin
								cmd.build_done = 1'b1;
							end else begin
								state_d = S_CLR;
							end
						end
					endcase
				end
			end
			S_RD_WAIT: begin
				cmd.read_finish = 1'b1;
				state_d = S_IDLE;
			end
			S_CLR: begin
				cmd.clr_write = 1'b1;
				if (st.clr_last) begin
					state_d = S_P_RD;
				end
			end
			S_P_RD: begin
				state_d = S_P_CHK;
			end
			S_P_CHK: begin
				if (!st.p_paired) begin
					cmd.p_latch = 1'b1;
					state_d = S_Q_RD;
				end else if (st.p_last) begin
					cmd.build_done = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.p_step = 1'b1;
					state_d = S_P_RD;
				end
			end
			S_Q_RD: begin
				cmd.q_issue = 1'b1;
				state_d = S_Q_CHK;
			end
			S_Q_CHK: begin
				if (st.q_match) begin
					state_d = S_PAIR_P;
				end else if (!st.q_first) begin
					cmd.q_step = 1'b1;
					state_d = S_Q_RD;
				end else if (st.p_last) begin
					cmd.build_done = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.p_step = 1'b1;
					state_d = S_P_RD;
				end
			end
			S_PAIR_P: begin
				cmd.pair_p = 1'b1;
				state_d = S_PAIR_Q;
			end
			S_PAIR_Q: begin
				cmd.pair_q = 1'b1;
				if (st.p_last) begin
					cmd.build_done = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.p_step = 1'b1;
					state_d = S_P_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_pair_two_writes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PAIR_P |=> state_q == S_PAIR_Q)
		else $error("pair write not followed by partner write");

	a_read_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && act == ACT_READ) |=> state_q == S_RD_WAIT)
		else $error("read item did not wait for RAM data");

	a_scan_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_CHK && !st.q_match && !st.q_first) |=> state_q == S_Q_RD)
		else $error("scan stopped early");

endmodule

/* hw/rtl/teab_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teab_dp
// Datapath: index and pair RAMs, fill counters, scan pointers, result regs.
// ----------------------------------------------------------------------------
module teab_dp #(
	parameter int MAX_FACES   = teab_pkg::DEF_MAX_FACES,
	parameter int VERTEX_BITS = teab_pkg::DEF_VERTEX_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  teab_pkg::cmd_t                 cmd,
	output teab_pkg::stat_t                st,
	input  logic [teab_pkg::VIN_W-1:0]     vertex_index,
	input  logic [teab_pkg::SLOT_IN_W-1:0] slot,
	output logic                           done,
	output logic [teab_pkg::STATUS_W-1:0]  status,
	output logic                           has_neighbor,
	output logic [teab_pkg::NB_OUT_W-1:0]  neighbor_face,
	output logic [teab_pkg::FC_OUT_W-1:0]  face_count
);
	import teab_pkg::*;

	localparam int SLOT_COUNT = 3 * MAX_FACES;
	localparam int ADDR_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int FCNT_W     = $clog2(MAX_FACES + 1);
	localparam int FACE_W     = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
	localparam int PAIR_W     = FACE_W + 1;

	logic [CNT_W-1:0]  loaded_q, nslots_q;
	logic [1:0]        mod_q;
	logic [FCNT_W-1:0] faces_q;
	logic              built_q;

	logic [ADDR_W-1:0] clr_q, p_slot_q, q_slot_q;
	logic [FACE_W-1:0] p_face_q, q_face_q;
	logic [1:0]        p_edge_q, q_edge_q;
	logic [VERTEX_BITS-1:0] from_q, to_q;
	logic [SLOT_IN_W-1:0]   rd_slot_q;

	logic            res_valid_q, res_has_q;
	status_t         res_status_q;
	logic [FACE_W-1:0] res_face_q;

	logic full;
	logic [ADDR_W-1:0] cur_slot, nxt_slot, pair_raddr, pair_waddr;
	logic [1:0] cur_edge;
	logic [VERTEX_BITS-1:0] a_rd, b_rd;
	logic [PAIR_W-1:0] pair_rd, pair_wdata;
	logic pair_we;
	logic [31:0] face_wide, fc_wide;

	assign full = (loaded_q == CNT_W'(SLOT_COUNT));

	// index RAM pair: A at the slot, B at the slot's end vertex
	assign cur_slot = cmd.q_issue ? q_slot_q : p_slot_q;
	assign cur_edge = cmd.q_issue ? q_edge_q : p_edge_q;
	assign nxt_slot = (cur_edge == 2'd2) ? cur_slot - ADDR_W'(2) : cur_slot + ADDR_W'(1);

	teab_ram #(.WIDTH(VERTEX_BITS), .DEPTH(SLOT_COUNT)) u_idx_a (
		.clk(clk), .we(cmd.load && !full), .waddr(loaded_q[ADDR_W-1:0]),
		.wdata(vertex_index[VERTEX_BITS-1:0]), .raddr(cur_slot), .rdata(a_rd)
	);

	teab_ram #(.WIDTH(VERTEX_BITS), .DEPTH(SLOT_COUNT)) u_idx_b (
		.clk(clk), .we(cmd.load && !full), .waddr(loaded_q[ADDR_W-1:0]),
		.wdata(vertex_index[VERTEX_BITS-1:0]), .raddr(nxt_slot), .rdata(b_rd)
	);

	// pair RAM word: {paired mark, neighbor face}
	always_comb begin
		pair_we    = cmd.clr_write | cmd.pair_p | cmd.pair_q;
		pair_waddr = clr_q;
		pair_wdata = '0;
		if (cmd.pair_p) begin
			pair_waddr = p_slot_q;
			pair_wdata = {1'b1, q_face_q};
		end else if (cmd.pair_q) begin
			pair_waddr = q_slot_q;
			pair_wdata = {1'b1, p_face_q};
		end
	end

	assign pair_raddr = cmd.read_issue ? ADDR_W'(32'(slot)) : cur_slot;

	teab_ram #(.WIDTH(PAIR_W), .DEPTH(SLOT_COUNT)) u_pair (
		.clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
		.raddr(pair_raddr), .rdata(pair_rd)
	);

	assign st.slots_zero = (nslots_q == '0);
	assign st.clr_last   = (CNT_W'(clr_q) + CNT_W'(1) == nslots_q);
	assign st.p_paired   = pair_rd[FACE_W];
	assign st.p_last     = (CNT_W'(p_slot_q) + CNT_W'(1) == nslots_q);
	assign st.q_first    = (q_slot_q == '0);
	assign st.q_match    = (q_face_q != p_face_q) && !pair_rd[FACE_W] &&
	                       (a_rd == to_q) && (b_rd == from_q);

	// fill counters and built flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			nslots_q <= '0;
			mod_q    <= '0;
			faces_q  <= '0;
			built_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				loaded_q <= '0;
				nslots_q <= '0;
				mod_q    <= '0;
				faces_q  <= '0;
				built_q  <= 1'b0;
			end else if (cmd.load && !full) begin
				loaded_q <= loaded_q + CNT_W'(1);
				built_q  <= 1'b0;
				if (mod_q == 2'd2) begin
					mod_q    <= '0;
					faces_q  <= faces_q + FCNT_W'(1);
					nslots_q <= nslots_q + CNT_W'(3);
				end else begin
					mod_q <= mod_q + 2'd1;
				end
			end else if (cmd.build_done) begin
				built_q <= 1'b1;
			end
		end
	end

	// scan pointers
	always_ff @(posedge clk) begin
		if (cmd.build_start) begin
			clr_q    <= '0;
			p_slot_q <= '0;
			p_face_q <= '0;
			p_edge_q <= '0;
		end
		if (cmd.clr_write) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
		if (cmd.p_step) begin
			p_slot_q <= p_slot_q + ADDR_W'(1);
			if (p_edge_q == 2'd2) begin
				p_edge_q <= '0;
				p_face_q <= p_face_q + FACE_W'(1);
			end else begin
				p_edge_q <= p_edge_q + 2'd1;
			end
		end
		if (cmd.p_latch) begin
			from_q   <= a_rd;
			to_q     <= b_rd;
			q_slot_q <= ADDR_W'(nslots_q - CNT_W'(1));
			q_face_q <= FACE_W'(faces_q - FCNT_W'(1));
			q_edge_q <= 2'd2;
		end
		if (cmd.q_step) begin
			q_slot_q <= q_slot_q - ADDR_W'(1);
			if (q_edge_q == 2'd0) begin
				q_edge_q <= 2'd2;
				q_face_q <= q_face_q - FACE_W'(1);
			end else begin
				q_edge_q <= q_edge_q - 2'd1;
			end
		end
		if (cmd.read_issue) begin
			rd_slot_q <= slot;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.load | cmd.clear | cmd.read_finish | cmd.build_done;
		end
	end

	always_ff @(posedge clk) begin
		res_status_q <= ST_OK;
		res_has_q    <= 1'b0;
		res_face_q   <= '0;
		if (cmd.load && full) begin
			res_status_q <= ST_FULL;
		end else if (cmd.read_finish) begin
			if (!built_q) begin
				res_status_q <= ST_NOT_BUILT;
			end else if (32'(rd_slot_q) >= 32'(nslots_q)) begin
				res_status_q <= ST_RANGE;
			end else if (pair_rd[FACE_W]) begin
				res_has_q  <= 1'b1;
				res_face_q <= pair_rd[FACE_W-1:0];
			end
		end
	end

	assign face_wide     = 32'(res_face_q);
	assign fc_wide       = 32'(faces_q);
	assign done          = res_valid_q;
	assign status        = res_status_q;
	assign has_neighbor  = res_has_q;
	assign neighbor_face = face_wide[NB_OUT_W-1:0];
	assign face_count    = fc_wide[FC_OUT_W-1:0];

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load || cmd.clear) |=> res_valid_q)
		else $error("load or clear gave no result");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (faces_q == '0 && !built_q))
		else $error("clear left faces behind");

	a_build_sets: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.build_done |=> built_q)
		else $error("build finished but flag not set");

endmodule

/* hw/rtl/triangle_edge_adjacency_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_edge_adjacency_builder
// Loads a triangle index buffer, pairs opposite face edges on build, and
// answers neighbor reads per edge slot.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  command  | start / busy          | action, vertex_index, slot
//  result   | done (1-cycle strobe) | status, has_neighbor, neighbor_face,
//           |                       | face_count
//
// Load and clear: busy stays low and the result strobes the next cycle.
// A read is busy in RD_WAIT while the registered pair RAM read completes.
// A build with N whole-face slots runs a clearing pass over those N pair RAM
// words, then a read and check per slot (P_RD, P_CHK), a read and compare
// per scanned candidate (Q_RD, Q_CHK) and two writes per pair made (PAIR_P,
// PAIR_Q); the candidate scan sets the worst case.
// Reset clears counters, built flag and sequencer; RAM contents stay as is.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module triangle_edge_adjacency_builder #(
	parameter int MAX_FACES   = teab_pkg::DEF_MAX_FACES,
	parameter int VERTEX_BITS = teab_pkg::DEF_VERTEX_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [teab_pkg::ACTION_W-1:0]  action,
	input  logic [teab_pkg::VIN_W-1:0]     vertex_index,
	input  logic [teab_pkg::SLOT_IN_W-1:0] slot,
	output logic                           done,
	output logic [teab_pkg::STATUS_W-1:0]  status,
	output logic                           has_neighbor,
	output logic [teab_pkg::NB_OUT_W-1:0]  neighbor_face,
	output logic [teab_pkg::FC_OUT_W-1:0]  face_count
);
	import teab_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// sequencer: decode the item, drive the clear pass and pairing scan
	teab_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// storage, counters and result registers
	teab_dp #(
		.MAX_FACES   (MAX_FACES),
		.VERTEX_BITS (VERTEX_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.vertex_index  (vertex_index),
		.slot          (slot),
		.done          (done),
		.status        (status),
		.has_neighbor  (has_neighbor),
		.neighbor_face (neighbor_face),
		.face_count    (face_count)
	);

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_edge_adjacency_builder. Loads small
// triangle meshes built from shared vertex pools, runs builds and reads back
// edge neighbors. Every result is checked field by field against an in-bench
// edge pairing predictor. Also covers buffer overflow, reads before a build,
// reads past the faces, trailing indices and degenerate faces.
// ----------------------------------------------------------------------------
module tb;
	import teab_pkg::*;

	localparam int SLOTS      = 3 * DEF_MAX_FACES;
	localparam int CYCLE_CAP  = 4000000;
	localparam int ITEM_GOAL  = 2000;

	typedef struct {
		status_t     st;
		logic        has;
		logic [9:0]  nb;
		logic [10:0] fc;
	} edge_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = ACT_LOAD;
	logic [31:0] vertex_index = '0;
	logic [11:0] slot = '0;
	logic        done;
	logic [1:0]  status;
	logic        has_neighbor;
	logic [9:0]  neighbor_face;
	logic [10:0] face_count;

	// predictor copy of the block state
	logic [31:0] vtx_mem [SLOTS];
	logic [10:0] nbr_mem [SLOTS];
	bit          paired  [SLOTS];
	int unsigned vtx_count;
	bit          adj_valid;

	edge_result_t adj_expect[$];
	int unsigned  idle_pct;
	int unsigned  items_sent, builds_sent, neighbors_seen, results_seen;
	int unsigned  mismatches;
	longint unsigned cycles;

	triangle_edge_adjacency_builder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .vertex_index(vertex_index), .slot(slot),
		.done(done), .status(status), .has_neighbor(has_neighbor),
		.neighbor_face(neighbor_face), .face_count(face_count)
	);

	always #1 clk = ~clk;

	// Watchdog: a hung handshake or lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				adj_expect.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Edge slot s runs from vertex 3f+e to vertex 3f+(e+1)%3.
	function automatic logic [31:0] edge_to(int unsigned s);
		return vtx_mem[s - s % 3 + (s % 3 + 1) % 3];
	endfunction

	// Pair every unpaired slot with the highest opposite slot of another face.
	function automatic void pair_edges();
		int unsigned nslots;
		nslots = (vtx_count / 3) * 3;
		foreach (paired[i]) paired[i] = 1'b0;
		for (int unsigned p = 0; p < nslots; p++) begin
			if (paired[p]) continue;
			for (int q = int'(nslots) - 1; q >= 0; q--) begin
				if (q == p || paired[q] || q / 3 == p / 3) continue;
				if (vtx_mem[q] == edge_to(p) && edge_to(q) == vtx_mem[p]) begin
					paired[p] = 1'b1;
					paired[q] = 1'b1;
					nbr_mem[p] = 11'(q / 3);
					nbr_mem[q] = 11'(p / 3);
					break;
				end
			end
		end
		adj_valid = 1'b1;
	endfunction

	function automatic edge_result_t predict_adjacency(action_t a, logic [31:0] v,
			logic [11:0] s);
		edge_result_t r;
		r.st  = ST_OK;
		r.has = 1'b0;
		r.nb  = '0;
		case (a)
			ACT_LOAD: begin
				if (vtx_count < SLOTS) begin
					vtx_mem[vtx_count] = v;
					vtx_count++;
					adj_valid = 1'b0;
				end else begin
					r.st = ST_FULL;
				end
			end
			ACT_BUILD: pair_edges();
			ACT_READ: begin
				if (!adj_valid) r.st = ST_NOT_BUILT;
				else if (s >= (vtx_count / 3) * 3) r.st = ST_RANGE;
				else if (paired[s]) begin
					r.has = 1'b1;
					r.nb  = nbr_mem[s][9:0];
				end
			end
			default: begin
				vtx_count = 0;
				adj_valid = 1'b0;
			end
		endcase
		r.fc = 11'(vtx_count / 3);
		return r;
	endfunction

	// Hold start high until the block takes the item; idle gaps come first.
	task automatic send_item(action_t a, logic [31:0] v = '0, logic [11:0] s = '0);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		action       <= a;
		vertex_index <= v;
		slot         <= s;
		do @(posedge clk); while (busy);
		adj_expect.push_back(predict_adjacency(a, v, s));
		items_sent++;
		if (a == ACT_BUILD) builds_sent++;
	endtask

	// Compare each strobed result with the oldest expectation.
	always @(posedge clk) begin
		edge_result_t e;
		if (arst_n && done) begin
			results_seen++;
			if (adj_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				e = adj_expect.pop_front();
				if (e.has) neighbors_seen++;
				if (status !== e.st || has_neighbor !== e.has ||
						neighbor_face !== e.nb || face_count !== e.fc) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch cycle %0d: exp st=%0d has=%0d nb=%0d fc=%0d, got st=%0d has=%0d nb=%0d fc=%0d",
							cycles, e.st, e.has, e.nb, e.fc,
							status, has_neighbor, neighbor_face, face_count);
				end
			end
		end
	end

	// Read before build, empty build, extreme indices, trailing and degenerate faces.
	task automatic test_directed();
		send_item(ACT_READ, '0, 12'd0);
		send_item(ACT_BUILD);
		send_item(ACT_READ, '0, 12'd0);
		send_item(ACT_LOAD, 32'h0000_0000);
		send_item(ACT_LOAD, 32'hFFFF_FFFF);
		send_item(ACT_LOAD, 32'h0000_0001);
		send_item(ACT_LOAD, 32'hFFFF_FFFF);
		send_item(ACT_LOAD, 32'h0000_0000);
		send_item(ACT_LOAD, 32'h0000_0007);
		// degenerate face carries the same edge both ways
		send_item(ACT_LOAD, 32'h0000_0005);
		send_item(ACT_LOAD, 32'h0000_0006);
		send_item(ACT_LOAD, 32'h0000_0005);
		// trailing index past the last whole face
		send_item(ACT_LOAD, 32'h0000_0001);
		send_item(ACT_BUILD);
		send_item(ACT_READ, '0, 12'd0);
		send_item(ACT_READ, '0, 12'd3);
		send_item(ACT_READ, '0, 12'd7);
		send_item(ACT_READ, '0, 12'd9);
		send_item(ACT_READ, '0, 12'hFFF);
		send_item(ACT_LOAD, 32'h0000_0002);
		send_item(ACT_READ, '0, 12'd0);
		send_item(ACT_CLEAR);
		send_item(ACT_READ, '0, 12'd0);
	endtask

	// Fill the buffer, drop one load, read the last slot unbuilt, then clear without building.
	task automatic test_buffer_full();
		send_item(ACT_CLEAR);
		for (int i = 0; i <= SLOTS; i++) send_item(ACT_LOAD, $urandom());
		send_item(ACT_READ, '0, 12'(SLOTS - 1));
		send_item(ACT_CLEAR);
	endtask

	// Small meshes from a shared vertex pool so that edges meet; mostly
	// load-build-read sequences, plus noise and broken sequences.
	task automatic test_random_meshes(int unsigned goal);
		logic [31:0] pool [6];
		int unsigned nf, npool, reads;
		while (items_sent < goal) begin
			if (vtx_count > 30 || $urandom_range(0, 4) != 0) send_item(ACT_CLEAR);
			npool = $urandom_range(3, 6);
			foreach (pool[i]) pool[i] = $urandom();
			if ($urandom_range(0, 3) == 0) pool[0] = 32'h0;
			if ($urandom_range(0, 3) == 0) pool[1] = 32'hFFFF_FFFF;
			nf = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
			for (int i = 0; i < 3 * nf + $urandom_range(0, 2); i++)
				send_item(ACT_LOAD, pool[$urandom_range(0, npool - 1)]);
			if ($urandom_range(0, 7) == 0) send_item(ACT_READ, '0, 12'($urandom_range(0, 4095)));
			send_item(ACT_BUILD);
			reads = $urandom_range(3, 10);
			for (int i = 0; i < reads; i++) begin
				if ($urandom_range(0, 5) == 0 || vtx_count < 3)
					send_item(ACT_READ, '0, 12'($urandom_range(0, 4095)));
				else
					send_item(ACT_READ, '0, 12'($urandom_range(0, (vtx_count / 3) * 3 - 1)));
			end
			// noise: any action with random fields
			if ($urandom_range(0, 3) == 0)
				send_item(action_t'($urandom_range(0, 3)), $urandom(), 12'($urandom_range(0, 4095)));
		end
	endtask

	initial begin
		cycles = 0;
		vtx_count = 0;
		adj_valid = 1'b0;
		idle_pct = 14;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_buffer_full();
		test_random_meshes(items_sent + ITEM_GOAL / 3);
		idle_pct = 70;
		test_random_meshes(items_sent + ITEM_GOAL / 3);
		idle_pct = 0;
		test_random_meshes(items_sent + ITEM_GOAL / 3);
		start <= 1'b0;

		while (adj_expect.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d items, %0d builds, %0d results, %0d reads with a neighbor",
			items_sent, builds_sent, results_seen, neighbors_seen);
		if (mismatches == 0 && adj_expect.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
